// ----- rtl/sfn_pkg.sv -----
// Shared types and constants for the short file name formatter.
package sfn_pkg;

  localparam int unsigned NameBytes  = 11;
  localparam int unsigned IdxW       = 4;
  localparam int unsigned QueueDepth = 2;

  localparam logic [7:0]      SpaceChar = 8'h20;
  localparam logic [IdxW-1:0] LastIdx   = IdxW'(NameBytes - 1);

  typedef struct packed {
    logic [NameBytes-1:0][7:0] name;
    logic                      ok;
  } sfn_rec_t;

endpackage

// ----- rtl/short_filename_formatter.sv -----
// Top level of the 8.3 short file name formatter.
//
//  channel  direction  handshake                 payload
//  cfg      in         cfg_we_i                  cfg_wdata_i (allow_wildcards)
//  in       in         in_valid_i / in_stall_o   char_code_i, end_of_name_i
//  out      out        out_valid_o / out_stall_i name_byte_o, byte_index_o,
//                                                name_ok_o, last_byte_o
//
//  Each character transaction is registered into the front end parse registers.
//  A terminator queues the finished name; the back end then loads it from the queue
//  into its output register and emits its 11 bytes at one per cycle unless stalled.
//  The two-entry queue lets the front end keep parsing while bytes drain;
//  a terminator stalls only when the queue is full.
//  Reset clears the parse state, sets the name store to spaces and disables wildcards.
module short_filename_formatter import sfn_pkg::*; #(
  parameter int unsigned MAX_INPUT_CHARS = 12
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_we_i,
  input  logic            cfg_wdata_i,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  logic [7:0]      char_code_i,
  input  logic            end_of_name_i,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output logic [7:0]      name_byte_o,
  output logic [IdxW-1:0] byte_index_o,
  output logic            name_ok_o,
  output logic            last_byte_o
);

  logic     push;
  sfn_rec_t push_data;
  logic     q_full;
  logic     q_valid;
  logic     pop;
  sfn_rec_t pop_data;

  sfn_front #(
    .MaxInputChars(MAX_INPUT_CHARS)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .char_code_i  (char_code_i),
    .end_of_name_i(end_of_name_i),
    .full_i       (q_full),
    .push_o       (push),
    .push_data_o  (push_data)
  );

  sfn_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_data_i(push_data),
    .full_o     (q_full),
    .pop_i      (pop),
    .valid_o    (q_valid),
    .pop_data_o (pop_data)
  );

  sfn_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_data_i    (pop_data),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .name_byte_o (name_byte_o),
    .byte_index_o(byte_index_o),
    .name_ok_o   (name_ok_o),
    .last_byte_o (last_byte_o)
  );

endmodule

// ----- rtl/sfn_front.sv -----
// Front end: checks name characters, builds the padded 8.3 name, queues it on terminator.
module sfn_front import sfn_pkg::*; #(
  parameter int unsigned MaxInputChars = 12
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     cfg_we_i,
  input  logic     cfg_wdata_i,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  logic [7:0] char_code_i,
  input  logic     end_of_name_i,
  input  logic     full_i,
  output logic     push_o,
  output sfn_rec_t push_data_o
);

  localparam int unsigned LenW   = $clog2(MaxInputChars + 2);
  localparam logic [LenW-1:0] LenMax = LenW'(MaxInputChars);
  localparam logic [LenW-1:0] LenSat = LenW'(MaxInputChars + 1);

  localparam logic [7:0] DotChar   = 8'h2E;
  localparam logic [7:0] StarChar  = 8'h2A;
  localparam logic [7:0] QuestChar = 8'h3F;
  localparam logic [7:0] EnqChar   = 8'h05;
  localparam logic [7:0] LowA      = 8'h61;
  localparam logic [7:0] LowZ      = 8'h7A;
  localparam logic [7:0] CaseDelta = 8'h20;

  localparam logic [3:0] BaseMax = 4'd8;
  localparam logic [3:0] BaseSat = 4'd9;
  localparam logic [2:0] ExtMax  = 3'd3;
  localparam logic [2:0] ExtSat  = 3'd4;

  function automatic logic is_forbidden(input logic [7:0] c);
    logic hit;
    case (c)
      8'h22, 8'h2B, 8'h2C, 8'h2F,
      8'h3A, 8'h3B, 8'h3C, 8'h3D, 8'h3E,
      8'h5B, 8'h5C, 8'h5D, 8'h7C: hit = 1'b1;
      default:                     hit = 1'b0;
    endcase
    return hit;
  endfunction

  logic                      allow_wild_q;
  logic [LenW-1:0]           len_q, len_d;
  logic [3:0]                base_q, base_d;
  logic [2:0]                ext_q, ext_d;
  logic                      dot_q, dot_d;
  logic                      rej_q, rej_d;
  logic [NameBytes-1:0][7:0] store_q, store_d;

  logic       take_char;
  logic       take_term;
  logic [7:0] upper_char;
  logic       name_ok;

  assign in_stall_o = in_valid_i && end_of_name_i && full_i;
  assign take_char  = in_valid_i && !in_stall_o && !end_of_name_i;
  assign take_term  = in_valid_i && !in_stall_o && end_of_name_i;

  assign upper_char = (char_code_i >= LowA && char_code_i <= LowZ) ?
                      (char_code_i - CaseDelta) : char_code_i;

  always_comb begin
    len_d   = len_q;
    base_d  = base_q;
    ext_d   = ext_q;
    dot_d   = dot_q;
    rej_d   = rej_q;
    store_d = store_q;
    if (take_term) begin
      len_d   = '0;
      base_d  = '0;
      ext_d   = '0;
      dot_d   = 1'b0;
      rej_d   = 1'b0;
      store_d = {NameBytes{SpaceChar}};
    end else if (take_char) begin
      if (len_q == '0 && char_code_i == DotChar) begin
        rej_d = 1'b1;
      end
      if (len_q != LenSat) begin
        len_d = len_q + 1'b1;
      end
      if (len_d > LenMax) begin
        rej_d = 1'b1;
      end
      if ((char_code_i <= SpaceChar && char_code_i != EnqChar) || char_code_i[7]) begin
        rej_d = 1'b1;
      end
      if (is_forbidden(char_code_i)) begin
        rej_d = 1'b1;
      end
      if ((char_code_i == StarChar || char_code_i == QuestChar) && !allow_wild_q) begin
        rej_d = 1'b1;
      end
      if (char_code_i == DotChar) begin
        if (dot_q) begin
          rej_d = 1'b1;
        end
        dot_d = 1'b1;
      end else if (!dot_q) begin
        if (base_q < BaseMax) begin
          store_d[base_q] = upper_char;
        end
        if (base_q != BaseSat) begin
          base_d = base_q + 1'b1;
        end
        if (base_d > BaseMax) begin
          rej_d = 1'b1;
        end
      end else begin
        if (ext_q < ExtMax) begin
          store_d[IdxW'(BaseMax) + IdxW'(ext_q)] = upper_char;
        end
        if (ext_q != ExtSat) begin
          ext_d = ext_q + 1'b1;
        end
        if (ext_d > ExtMax) begin
          rej_d = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      allow_wild_q <= 1'b0;
      len_q        <= '0;
      base_q       <= '0;
      ext_q        <= '0;
      dot_q        <= 1'b0;
      rej_q        <= 1'b0;
      store_q      <= {NameBytes{SpaceChar}};
    end else begin
      if (cfg_we_i) begin
        allow_wild_q <= cfg_wdata_i;
      end
      len_q   <= len_d;
      base_q  <= base_d;
      ext_q   <= ext_d;
      dot_q   <= dot_d;
      rej_q   <= rej_d;
      store_q <= store_d;
    end
  end

  assign name_ok          = !rej_q && (len_q != '0);
  assign push_o           = take_term;
  assign push_data_o.ok   = name_ok;
  assign push_data_o.name = name_ok ? store_q : {NameBytes{SpaceChar}};

endmodule

// ----- rtl/sfn_queue.sv -----
// Two-entry queue of finished names between front and back end.
module sfn_queue import sfn_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_i,
  input  sfn_rec_t push_data_i,
  output logic     full_o,
  input  logic     pop_i,
  output logic     valid_o,
  output sfn_rec_t pop_data_o
);

  localparam int unsigned PtrW = $clog2(QueueDepth);
  localparam int unsigned CntW = $clog2(QueueDepth + 1);

  sfn_rec_t        mem_q [QueueDepth];
  logic [PtrW-1:0] wr_ptr_q;
  logic [PtrW-1:0] rd_ptr_q;
  logic [CntW-1:0] cnt_q;

  assign full_o     = cnt_q == CntW'(QueueDepth);
  assign valid_o    = cnt_q != '0;
  assign pop_data_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      case ({push_i, pop_i})
        2'b10:   cnt_q <= cnt_q + 1'b1;
        2'b01:   cnt_q <= cnt_q - 1'b1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

`ifndef SYNTHESIS
  assert property (@(posedge clk_i) disable iff (!rst_ni) full_o |-> !push_i)
    else $error("queue overflow");
  assert property (@(posedge clk_i) disable iff (!rst_ni) !valid_o |-> !pop_i)
    else $error("queue underflow");
`endif

endmodule

// ----- rtl/sfn_back.sv -----
// Back end: streams the eleven bytes of each queued name through an output register.
module sfn_back import sfn_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            q_valid_i,
  input  sfn_rec_t        q_data_i,
  output logic            pop_o,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output logic [7:0]      name_byte_o,
  output logic [IdxW-1:0] byte_index_o,
  output logic            name_ok_o,
  output logic            last_byte_o
);

  logic            out_valid_q;
  logic [IdxW-1:0] idx_q;
  sfn_rec_t        rec_q;
  logic            out_take;
  logic            at_last;

  assign out_take = out_valid_q && !out_stall_i;
  assign at_last  = idx_q == LastIdx;
  assign pop_o    = q_valid_i && (!out_valid_q || (out_take && at_last));

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      rec_q <= q_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      idx_q       <= '0;
    end else if (pop_o) begin
      out_valid_q <= 1'b1;
      idx_q       <= '0;
    end else if (out_take) begin
      if (at_last) begin
        out_valid_q <= 1'b0;
      end else begin
        idx_q <= idx_q + 1'b1;
      end
    end
  end

  assign out_valid_o  = out_valid_q;
  assign name_byte_o  = rec_q.name[idx_q];
  assign byte_index_o = idx_q;
  assign name_ok_o    = rec_q.ok;
  assign last_byte_o  = at_last;

`ifndef SYNTHESIS
  assert property (@(posedge clk_i) disable iff (!rst_ni) out_valid_q |-> idx_q <= LastIdx)
    else $error("byte index out of range");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_stall_i) |=> (out_valid_q && $stable(idx_q)))
    else $error("stalled byte advanced");
`endif

endmodule

// ----- dv/short_filename_formatter_test.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for the 8.3 short file name formatter.
module short_filename_formatter_test;
  import sfn_pkg::*;

  localparam int unsigned MaxChars   = 12;
  localparam int unsigned BaseMax    = 8;
  localparam int unsigned ExtMax     = 3;
  localparam int unsigned TotalItems = 250;
  localparam int unsigned PhaseNames = 12;
  localparam int unsigned TailItems  = 40;
  localparam int unsigned Settle     = 4;
  localparam int unsigned HoldLen    = 120;
  localparam int unsigned IdleLimit  = 3000;

  localparam logic [7:0] DotChar   = 8'h2E;
  localparam logic [7:0] KeepChar  = 8'h05;
  localparam logic [7:0] StarChar  = 8'h2A;
  localparam logic [7:0] QmarkChar = 8'h3F;
  localparam logic [7:0] DelChar   = 8'h7F;
  localparam logic [7:0] LowA      = 8'h61;
  localparam logic [7:0] LowZ      = 8'h7A;
  localparam logic [7:0] CaseGap   = 8'h20;
  localparam string      OtherChars = "!#$%&'()-@^_{}~";

  typedef enum logic [1:0] {ACT_ITEM, ACT_CFG, ACT_DRAIN} act_e;

  typedef struct {
    act_e       act;
    logic [7:0] ch;
    logic       eon;
  } name_step_t;

  typedef struct {
    logic [7:0]      ch;
    logic [IdxW-1:0] idx;
    logic            ok;
    logic            last;
  } out_byte_t;

  logic            clk_i         = 1'b0;
  logic            rst_ni        = 1'b0;
  logic            cfg_we_i      = 1'b0;
  logic            cfg_wdata_i   = 1'b0;
  logic            in_valid_i    = 1'b0;
  logic            in_stall_o;
  logic [7:0]      char_code_i   = 8'h00;
  logic            end_of_name_i = 1'b0;
  logic            out_valid_o;
  logic            out_stall_i   = 1'b0;
  logic [7:0]      name_byte_o;
  logic [IdxW-1:0] byte_index_o;
  logic            name_ok_o;
  logic            last_byte_o;

  short_filename_formatter #(
    .MAX_INPUT_CHARS(MaxChars)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .char_code_i   (char_code_i),
    .end_of_name_i (end_of_name_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .name_byte_o   (name_byte_o),
    .byte_index_o  (byte_index_o),
    .name_ok_o     (name_ok_o),
    .last_byte_o   (last_byte_o)
  );

  name_step_t  name_steps[$];
  out_byte_t   expected_bytes[$];

  logic [7:0]  name_buf [NameBytes];
  logic [3:0]  char_count;
  logic [3:0]  base_count;
  logic [2:0]  ext_count;
  logic        saw_dot;
  logic        bad_name;
  logic        wild_en;

  int unsigned items_queued  = 0;
  int unsigned names_queued  = 0;
  int unsigned hold_at       = 0;
  int unsigned mismatches    = 0;
  int unsigned results_seen  = 0;
  int unsigned ok_names      = 0;
  int unsigned cfg_writes    = 0;
  int unsigned stall_cycles  = 0;
  int unsigned quiet         = 0;
  int unsigned gap_left      = 0;
  int unsigned hold_left     = 0;
  int unsigned burst_left    = 0;
  int unsigned idle_run      = 0;
  logic        held          = 1'b0;
  logic        calm          = 1'b0;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic void clear_name();
    for (int k = 0; k < NameBytes; k++) name_buf[k] = SpaceChar;
    char_count = '0;
    base_count = '0;
    ext_count  = '0;
    saw_dot    = 1'b0;
    bad_name   = 1'b0;
  endfunction

  function automatic logic is_forbidden(input logic [7:0] ch);
    case (ch)
      8'h22, 8'h2B, 8'h2C, 8'h2F, 8'h3A, 8'h3B, 8'h3C, 8'h3D, 8'h3E,
      8'h5B, 8'h5C, 8'h5D, 8'h7C: return 1'b1;
      default:                    return 1'b0;
    endcase
  endfunction

  function automatic void format_name_step(input logic [7:0] ch, input logic eon);
    logic [7:0] up;
    logic       accept;
    if (eon) begin
      accept = !bad_name && char_count != 0;
      for (int k = 0; k < NameBytes; k++) begin
        expected_bytes.push_back('{accept ? name_buf[k] : SpaceChar, IdxW'(k), accept,
                                   k == NameBytes - 1});
      end
      clear_name();
    end else begin
      if (char_count == 0 && ch == DotChar) bad_name = 1'b1;
      if (char_count < MaxChars + 1) char_count++;
      if (char_count > MaxChars) bad_name = 1'b1;
      if ((ch <= SpaceChar && ch != KeepChar) || ch[7]) bad_name = 1'b1;
      if (is_forbidden(ch)) bad_name = 1'b1;
      if ((ch == StarChar || ch == QmarkChar) && !wild_en) bad_name = 1'b1;
      if (ch == DotChar) begin
        if (saw_dot) bad_name = 1'b1;
        saw_dot = 1'b1;
      end else begin
        up = (ch >= LowA && ch <= LowZ) ? ch - CaseGap : ch;
        if (!saw_dot) begin
          if (base_count < BaseMax) name_buf[base_count] = up;
          if (base_count < BaseMax + 1) base_count++;
          if (base_count > BaseMax) bad_name = 1'b1;
        end else begin
          if (ext_count < ExtMax) name_buf[BaseMax + ext_count] = up;
          if (ext_count < ExtMax + 1) ext_count++;
          if (ext_count > ExtMax) bad_name = 1'b1;
        end
      end
    end
  endfunction

  function automatic void push_item(input logic [7:0] ch, input logic eon);
    name_steps.push_back('{ACT_ITEM, ch, eon});
    items_queued++;
    if (eon) names_queued++;
  endfunction

  function automatic void push_term();
    push_item(8'($urandom_range(0, 255)), 1'b1);
  endfunction

  function automatic void push_name(input string text);
    for (int k = 0; k < text.len(); k++) push_item(text[k], 1'b0);
    push_term();
  endfunction

  function automatic void push_cfg(input logic value);
    name_steps.push_back('{ACT_CFG, {7'd0, value}, 1'b0});
  endfunction

  function automatic void push_drain();
    name_steps.push_back('{ACT_DRAIN, 8'h00, 1'b0});
  endfunction

  function automatic logic [7:0] legal_char();
    case ($urandom_range(0, 9))
      0, 1, 2: return 8'(8'h41 + $urandom_range(0, 25));
      3, 4:    return 8'(LowA + $urandom_range(0, 25));
      5:       return 8'(8'h30 + $urandom_range(0, 9));
      6:       return OtherChars[$urandom_range(0, OtherChars.len() - 1)];
      7:       return $urandom_range(0, 1) ? KeepChar : DelChar;
      8:       return $urandom_range(0, 1) ? StarChar : QmarkChar;
      default: return 8'(8'h41 + $urandom_range(0, 25));
    endcase
  endfunction

  function automatic void push_random_name();
    int unsigned shape;
    int unsigned base_n;
    int unsigned ext_n;
    int unsigned len;
    shape = $urandom_range(0, 9);
    if (shape < 6) begin
      base_n = $urandom_range(1, BaseMax);
      ext_n  = $urandom_range(0, ExtMax);
      for (int k = 0; k < base_n; k++) push_item(legal_char(), 1'b0);
      if (ext_n != 0 || $urandom_range(0, 3) == 0) push_item(DotChar, 1'b0);
      for (int k = 0; k < ext_n; k++) push_item(legal_char(), 1'b0);
    end else if (shape < 9) begin
      len = $urandom_range(0, 15);
      for (int k = 0; k < len; k++) begin
        case ($urandom_range(0, 9))
          0:       push_item(DotChar, 1'b0);
          1:       push_item(8'($urandom_range(0, 255)), 1'b0);
          default: push_item(legal_char(), 1'b0);
        endcase
      end
    end else begin
      len = $urandom_range(0, 6);
      for (int k = 0; k < len; k++) push_item(8'($urandom_range(0, 255)), 1'b0);
    end
    push_term();
  endfunction

  function automatic void compare_field(input string field, input int unsigned want,
                                        input int unsigned got);
    if (want != got) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
    end
  endfunction

  // driver
  always @(posedge clk_i) begin
    logic nxt_valid;
    logic nxt_we;
    nxt_valid = in_valid_i;
    nxt_we    = 1'b0;
    calm      = name_steps.size() < TailItems;
    if (in_valid_i && !in_stall_o) begin
      format_name_step(char_code_i, end_of_name_i);
      nxt_valid = 1'b0;
    end else if (in_valid_i) begin
      stall_cycles++;
    end
    quiet = (expected_bytes.size() == 0 && !out_valid_o && !in_valid_i) ? quiet + 1 : 0;
    if (rst_ni && !nxt_valid) begin
      if (gap_left != 0) begin
        gap_left--;
      end else if (name_steps.size() != 0) begin
        case (name_steps[0].act)
          ACT_ITEM: begin
            if (!calm && $urandom_range(0, 7) == 0) begin
              gap_left = $urandom_range(0, 8);
            end else begin
              char_code_i   <= name_steps[0].ch;
              end_of_name_i <= name_steps[0].eon;
              nxt_valid     = 1'b1;
              void'(name_steps.pop_front());
            end
          end
          ACT_CFG: begin
            if (quiet >= Settle) begin
              cfg_wdata_i <= name_steps[0].ch[0];
              wild_en     = name_steps[0].ch[0];
              nxt_we      = 1'b1;
              cfg_writes++;
              void'(name_steps.pop_front());
            end
          end
          ACT_DRAIN: begin
            if (quiet >= Settle) void'(name_steps.pop_front());
          end
          default: ;
        endcase
      end
    end
    in_valid_i <= nxt_valid;
    cfg_we_i   <= nxt_we;
  end

  // monitor and receiver back-pressure
  always @(posedge clk_i) begin
    logic      nxt_stall;
    out_byte_t want;
    if (out_valid_o && !out_stall_i) begin
      results_seen++;
      if (last_byte_o && name_ok_o) ok_names++;
      if (expected_bytes.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected transaction, expected none, actual byte %0h index %0d",
                 $time, name_byte_o, byte_index_o);
      end else begin
        want = expected_bytes.pop_front();
        compare_field("name_byte", want.ch, name_byte_o);
        compare_field("byte_index", want.idx, byte_index_o);
        compare_field("name_ok", want.ok, name_ok_o);
        compare_field("last_byte", want.last, last_byte_o);
      end
    end
    if (hold_left != 0) begin
      hold_left--;
      nxt_stall = 1'b1;
    end else if (!held && hold_at != 0 && results_seen >= hold_at) begin
      held      = 1'b1;
      hold_left = HoldLen - 1;
      nxt_stall = 1'b1;
    end else if (burst_left != 0) begin
      burst_left--;
      nxt_stall = 1'b1;
    end else if (!calm && $urandom_range(0, 7) == 0) begin
      burst_left = $urandom_range(0, 8);
      nxt_stall  = 1'b1;
    end else begin
      nxt_stall = 1'b0;
    end
    out_stall_i <= nxt_stall;
  end

  // watchdog
  always @(posedge clk_i) begin
    if (!rst_ni || cfg_we_i || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      idle_run = 0;
    end else begin
      idle_run++;
      if (idle_run >= IdleLimit) begin
        $display("%0t: no transaction for %0d cycles", $time, IdleLimit);
        $display("** short_filename_formatter: FAILED **");
        $finish;
      end
    end
  end

  initial begin
    logic cfg_val;
    wild_en = 1'b0;
    clear_name();

    push_cfg(1'b0);
    push_term();
    push_name(".A");
    push_item(KeepChar, 1'b0);
    push_item(DelChar, 1'b0);
    push_item(DotChar, 1'b0);
    push_term();
    push_item(8'hFF, 1'b0);
    push_term();
    push_name("|");
    push_name("A..");
    push_name("*");
    push_drain();
    push_cfg(1'b1);
    push_name("?");
    push_name("abcdefgh.ijk");
    push_drain();
    push_cfg(1'b0);
    hold_at = NameBytes * (names_queued + 2);

    cfg_val = 1'b0;
    while (items_queued < TotalItems) begin
      for (int n = 0; n < PhaseNames && items_queued < TotalItems; n++) push_random_name();
      push_drain();
      cfg_val = ~cfg_val;
      push_cfg(cfg_val);
    end

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (name_steps.size() != 0 || in_valid_i) @(posedge clk_i);
    while (expected_bytes.size() != 0) @(posedge clk_i);
    repeat (4 * Settle) @(posedge clk_i);

    $display("Sent %0d names in %0d items with %0d register writes; %0d names accepted.",
             names_queued, items_queued, cfg_writes, ok_names);
    $display("Checked %0d output bytes; input held back for %0d cycles.",
             results_seen, stall_cycles);
    if (mismatches == 0) begin
      $display("** short_filename_formatter: PASSED **");
    end else begin
      $display("** short_filename_formatter: FAILED **");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/sfn_pkg.sv
rtl/sfn_front.sv
rtl/sfn_queue.sv
rtl/sfn_back.sv
rtl/short_filename_formatter.sv
dv/short_filename_formatter_test.sv
